### design/atisd_pkg.sv
`default_nettype none
package atisd_pkg;

   // Table geometry
   localparam int DEPTH  = 64;
   localparam int IDX_W  = 6;
   localparam int CNT_W  = 7;
   localparam int DATA_W = 32;

   // Request modes
   localparam logic [1:0] MODE_INSERT  = 2'd0;
   localparam logic [1:0] MODE_DISPLAY = 2'd1;
   localparam logic [1:0] MODE_SEARCH  = 2'd2;
   localparam logic [1:0] MODE_DELETE  = 2'd3;

   // Result status codes
   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_FULL     = 2'd1;
   localparam logic [1:0] STAT_EMPTY    = 2'd2;
   localparam logic [1:0] STAT_NOTFOUND = 2'd3;

   typedef struct packed {
      logic [1:0]               mode;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]               status;
      logic [IDX_W-1:0]         index;
      logic signed [DATA_W-1:0] element;
      logic [CNT_W-1:0]         entry_count;
      logic                     last;
   } rsp_type;

endpackage
`default_nettype wire

### design/atisd_ram.sv
`default_nettype none
module atisd_ram #(
   parameter int ADDR_W = 6,
   parameter int DATA_W = 32
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [2**ADDR_W];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port; data holds while no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

### design/array_table_insert_search_delete_unit.sv
`default_nettype none
// Unsorted table of up to 64 signed 32-bit values held in one single-port-read,
// single-port-write RAM with a registered read. One request is worked at a time.
// Insert appends at the tail. Search scans one entry per cycle; delete stops its
// scan at the match and then runs a shift pass that moves each later entry down
// one place per cycle. Display reads each entry and then sends it as its own
// result, and waits before each send while the output register is stalled.
// Search, delete and display on an empty table give one result with status
// empty; every request's final result carries last = 1. A new request is taken
// while the previous result still waits in the output register.
module array_table_insert_search_delete_unit
   import atisd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_EMIT     = 3'd1;
   localparam logic [2:0] S_SEARCH   = 3'd2;
   localparam logic [2:0] S_SHIFT    = 3'd3;
   localparam logic [2:0] S_DISP_RD  = 3'd4;
   localparam logic [2:0] S_DISP_OUT = 3'd5;

   logic [2:0]               state_ff, state_in;
   logic [1:0]               mode_ff, mode_in;
   logic signed [DATA_W-1:0] value_ff, value_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]         rd_idx_ff, rd_idx_in;
   logic                     chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]         chk_idx_ff, chk_idx_in;
   logic                     sh_vld_ff, sh_vld_in;
   logic [IDX_W-1:0]         wr_idx_ff, wr_idx_in;
   rsp_type                  res_ff, res_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff, rsp_in;

   logic                     ram_wr_en;
   logic [IDX_W-1:0]         ram_wr_addr;
   logic [DATA_W-1:0]        ram_wr_data;
   logic                     ram_rd_en;
   logic [IDX_W-1:0]         ram_rd_addr;
   logic [DATA_W-1:0]        ram_rd_data;

   logic                     out_free;
   logic                     accept;
   logic                     emit;
   logic [IDX_W-1:0]         cnt_m1;
   logic                     match;

   atisd_ram #(
      .ADDR_W(IDX_W),
      .DATA_W(DATA_W)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign cnt_m1    = IDX_W'(count_ff - CNT_W'(1));
   assign match     = chk_vld_ff && (ram_rd_data == DATA_W'(value_ff));

   // Sequence requests through the table
   always_comb begin
      state_in    = state_ff;
      mode_in     = mode_ff;
      value_in    = value_ff;
      count_in    = count_ff;
      rd_idx_in   = rd_idx_ff;
      chk_vld_in  = 1'b0;
      chk_idx_in  = chk_idx_ff;
      sh_vld_in   = 1'b0;
      wr_idx_in   = wr_idx_ff;
      res_in      = res_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = wr_idx_ff;
      ram_wr_data = ram_rd_data;
      ram_rd_en   = 1'b0;
      ram_rd_addr = rd_idx_ff[IDX_W-1:0];
      emit        = 1'b0;
      rsp_in      = rsp_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               mode_in   = req_data.mode;
               value_in  = req_data.value;
               rd_idx_in = '0;
               res_in    = '{status: STAT_OK, index: '0, element: '0,
                             entry_count: count_ff, last: 1'b1};
               if (req_data.mode == MODE_INSERT) begin
                  if (count_ff >= CNT_W'(DEPTH)) begin
                     res_in.status = STAT_FULL;
                  end else begin
                     // Append at the tail
                     ram_wr_en          = 1'b1;
                     ram_wr_addr        = count_ff[IDX_W-1:0];
                     ram_wr_data        = DATA_W'(req_data.value);
                     count_in           = count_ff + CNT_W'(1);
                     res_in.entry_count = count_ff + CNT_W'(1);
                  end
                  state_in = S_EMIT;
               end else if (count_ff == '0) begin
                  res_in.status = STAT_EMPTY;
                  state_in      = S_EMIT;
               end else if (req_data.mode == MODE_DISPLAY) begin
                  state_in = S_DISP_RD;
               end else begin
                  state_in = S_SEARCH;
               end
            end
         end

         S_EMIT: begin
            if (out_free) begin
               emit     = 1'b1;
               rsp_in   = res_ff;
               state_in = S_IDLE;
            end
         end

         S_SEARCH: begin
            if (match) begin
               res_in.index     = chk_idx_ff;
               if (mode_ff == MODE_DELETE) begin
                  // Shift later entries down one place
                  rd_idx_in = CNT_W'(chk_idx_ff) + CNT_W'(1);
                  wr_idx_in = chk_idx_ff;
                  state_in  = S_SHIFT;
               end else begin
                  state_in = S_EMIT;
               end
            end else if (chk_vld_ff && chk_idx_ff == cnt_m1) begin
               res_in.status = STAT_NOTFOUND;
               state_in      = S_EMIT;
            end else if (rd_idx_ff < count_ff) begin
               // Issue next read; compare it next cycle
               ram_rd_en  = 1'b1;
               chk_vld_in = 1'b1;
               chk_idx_in = rd_idx_ff[IDX_W-1:0];
               rd_idx_in  = rd_idx_ff + CNT_W'(1);
            end
         end

         S_SHIFT: begin
            if (sh_vld_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = wr_idx_ff;
               ram_wr_data = ram_rd_data;
               wr_idx_in   = wr_idx_ff + IDX_W'(1);
            end
            if (rd_idx_ff < count_ff) begin
               ram_rd_en = 1'b1;
               sh_vld_in = 1'b1;
               rd_idx_in = rd_idx_ff + CNT_W'(1);
            end else if (!sh_vld_ff) begin
               count_in           = count_ff - CNT_W'(1);
               res_in.entry_count = count_ff - CNT_W'(1);
               state_in           = S_EMIT;
            end
         end

         S_DISP_RD: begin
            ram_rd_en = 1'b1;
            state_in  = S_DISP_OUT;
         end

         S_DISP_OUT: begin
            if (out_free) begin
               emit   = 1'b1;
               rsp_in = '{status: STAT_OK, index: rd_idx_ff[IDX_W-1:0],
                          element: $signed(ram_rd_data), entry_count: count_ff,
                          last: (rd_idx_ff[IDX_W-1:0] == cnt_m1)};
               if (rd_idx_ff[IDX_W-1:0] == cnt_m1) begin
                  state_in = S_IDLE;
               end else begin
                  rd_idx_in = rd_idx_ff + CNT_W'(1);
                  state_in  = S_DISP_RD;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Hold the result until taken
      rsp_valid_in = emit ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         chk_vld_ff   <= 1'b0;
         sh_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         chk_vld_ff   <= chk_vld_in;
         sh_vld_ff    <= sh_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      mode_ff    <= mode_in;
      value_ff   <= value_in;
      rd_idx_ff  <= rd_idx_in;
      chk_idx_ff <= chk_idx_in;
      wr_idx_ff  <= wr_idx_in;
      res_ff     <= res_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire
